FILE: rtl/sbvt_pkg.sv
// ----------------------------------------------------------------------------
// sbvt_pkg
// Shared types, character codes and helpers for the SQL bind-variable
// tokenizer.
// ----------------------------------------------------------------------------
package sbvt_pkg;

  // Upper bound on words that one text byte can cause
  localparam int MaxResults = 5;
  localparam int CountW     = $clog2(MaxResults + 1);

  // Character codes
  localparam logic [7:0] ColonChar  = 8'h3A;
  localparam logic [7:0] QuoteChar  = 8'h27;
  localparam logic [7:0] EqualChar  = 8'h3D;
  localparam logic [7:0] UnderChar  = 8'h5F;
  localparam logic [7:0] DollarChar = 8'h24;
  localparam logic [7:0] HashChar   = 8'h23;

  typedef enum logic [1:0] {
    MODE_BASE  = 2'd0,
    MODE_QUOTE = 2'd1,
    MODE_NAME  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_FRAG_BYTE   = 3'd0,
    KIND_FRAG_END    = 3'd1,
    KIND_NAME_BYTE   = 3'd2,
    KIND_NAME_END    = 3'd3,
    KIND_NAME_CANCEL = 3'd4
  } kind_t;

  // One output word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  // All words caused by one text byte
  typedef struct packed {
    token_t [MaxResults-1:0] ent;
    logic   [CountW-1:0]     cnt;
  } token_list_t;

  // ASCII letters, digits, '_', '$' and '#'
  function automatic logic is_name_byte(input logic [7:0] c);
    is_name_byte = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A) || c == UnderChar ||
                   c == DollarChar || c == HashChar;
  endfunction

endpackage

FILE: rtl/sbvt_scan.sv
// ----------------------------------------------------------------------------
// sbvt_scan
// Scanner state and the per-byte decision: turns one text byte into the
// list of words it causes and advances the scan state on accept.
// ----------------------------------------------------------------------------
module sbvt_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                is_final,
  output sbvt_pkg::token_list_t list
);
  import sbvt_pkg::*;

  mode_t      scan_mode, scan_mode_next;
  logic       colon_pending, colon_pending_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic       quote_nonempty, quote_nonempty_next;

  // Decide the words and next state for the byte on the port
  always_comb begin
    token_list_t l;
    logic        base_go;
    logic        name_go;
    l         = '0;
    base_go   = 1'b0;
    name_go   = 1'b0;
    scan_mode_next      = scan_mode;
    colon_pending_next  = 1'b0;
    quote_nonempty_next = quote_nonempty;

    if (colon_pending) begin
      if (text_byte == ColonChar) begin
        l.ent[l.cnt] = '{KIND_FRAG_BYTE, ColonChar, 1'b0};
        l.cnt        = l.cnt + 1'b1;
        base_go      = 1'b1;
      end else begin
        l.ent[l.cnt]   = '{KIND_FRAG_END, 8'h00, 1'b0};
        l.cnt          = l.cnt + 1'b1;
        scan_mode_next = MODE_NAME;
        name_go        = 1'b1;
      end
    end else if (scan_mode == MODE_QUOTE) begin
      if (text_byte == QuoteChar && (previous_byte != QuoteChar || !quote_nonempty)) begin
        scan_mode_next = MODE_BASE;
      end
      quote_nonempty_next = 1'b1;
      l.ent[l.cnt] = '{KIND_FRAG_BYTE, text_byte, 1'b0};
      l.cnt        = l.cnt + 1'b1;
    end else if (scan_mode == MODE_NAME) begin
      name_go = 1'b1;
    end else begin
      base_go = 1'b1;
    end

    // Name handling; a byte that ends the name falls through to base text
    if (name_go) begin
      if (text_byte == EqualChar) begin
        l.ent[l.cnt]   = '{KIND_NAME_CANCEL, 8'h00, 1'b0};
        l.cnt          = l.cnt + 1'b1;
        scan_mode_next = MODE_BASE;
      end else if (is_name_byte(text_byte)) begin
        l.ent[l.cnt] = '{KIND_NAME_BYTE, text_byte, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end else begin
        l.ent[l.cnt]   = '{KIND_NAME_END, 8'h00, 1'b0};
        l.cnt          = l.cnt + 1'b1;
        scan_mode_next = MODE_BASE;
        base_go        = 1'b1;
      end
    end

    // Base text handling
    if (base_go) begin
      if (text_byte == QuoteChar) begin
        scan_mode_next      = MODE_QUOTE;
        quote_nonempty_next = 1'b0;
        l.ent[l.cnt] = '{KIND_FRAG_BYTE, text_byte, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end else if (text_byte == ColonChar && previous_byte != ColonChar) begin
        colon_pending_next = 1'b1;
      end else begin
        l.ent[l.cnt] = '{KIND_FRAG_BYTE, text_byte, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end
    end

    previous_byte_next = text_byte;

    // Close the statement on its last byte and return to reset state
    if (is_final) begin
      if (colon_pending_next) begin
        l.ent[l.cnt] = '{KIND_FRAG_END, 8'h00, 1'b0};
        l.cnt        = l.cnt + 1'b1;
        l.ent[l.cnt] = '{KIND_NAME_END, 8'h00, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end else if (scan_mode_next == MODE_NAME) begin
        l.ent[l.cnt] = '{KIND_NAME_END, 8'h00, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end else begin
        l.ent[l.cnt] = '{KIND_FRAG_END, 8'h00, 1'b0};
        l.cnt        = l.cnt + 1'b1;
      end
      scan_mode_next      = MODE_BASE;
      colon_pending_next  = 1'b0;
      previous_byte_next  = 8'h00;
      quote_nonempty_next = 1'b0;
    end

    // Mark the closing word of this byte
    if (l.cnt != '0) begin
      l.ent[l.cnt - 1'b1].last = 1'b1;
    end
    list = l;
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_BASE;
      colon_pending  <= 1'b0;
      previous_byte  <= 8'h00;
      quote_nonempty <= 1'b0;
    end else if (accept) begin
      scan_mode      <= scan_mode_next;
      colon_pending  <= colon_pending_next;
      previous_byte  <= previous_byte_next;
      quote_nonempty <= quote_nonempty_next;
    end
  end

  // A held colon only exists in base text
  a_pend_base: assert property (@(posedge clk) disable iff (rst)
    colon_pending |-> scan_mode == MODE_BASE)
    else $error("colon held outside base text");

  // The last byte of a statement leaves the scanner in reset state
  a_final_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && is_final) |=> (scan_mode == MODE_BASE && !colon_pending &&
                              previous_byte == 8'h00 && !quote_nonempty))
    else $error("scanner not cleared after last byte");

endmodule

FILE: rtl/sbvt_drain.sv
// ----------------------------------------------------------------------------
// sbvt_drain
// Result register: holds the words of one text byte and hands them out one
// per cycle on the token channel while token_stall is low.
// ----------------------------------------------------------------------------
module sbvt_drain (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sbvt_pkg::token_list_t list,
  output logic                  ready,
  output logic                  token_valid,
  input  logic                  token_stall,
  output sbvt_pkg::token_t      token
);
  import sbvt_pkg::*;

  token_t [MaxResults-1:0] ent;
  logic   [CountW-1:0]     cnt;
  logic   [CountW-1:0]     idx;
  logic                    busy;
  logic                    take;
  logic                    done_now;

  assign busy        = (idx != cnt);
  assign take        = busy && !token_stall;
  assign done_now    = take && ((idx + 1'b1) == cnt);
  assign ready       = !busy || done_now;
  assign token_valid = busy;
  assign token       = ent[idx];

  // Hold the word list payload
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= list.ent;
    end
  end

  // Advance the read index; a new load replaces a finished list
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= list.cnt;
      idx <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  // Read index never runs past the list
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= cnt && cnt <= CountW'(MaxResults))
    else $error("read index beyond word list");

  // A stalled word is not dropped
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && token_stall) |=> (busy && $stable(idx)))
    else $error("stalled word lost");

  // Only the last word of a list carries the closing mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    busy |-> (token.last == ((idx + 1'b1) == cnt)))
    else $error("closing mark misplaced");

endmodule

FILE: rtl/sql_bind_variable_tokenizer.sv
// ----------------------------------------------------------------------------
// sql_bind_variable_tokenizer
// Splits SQL text into fragment bytes and bind-variable names, one text
// byte per word in, tagged words out.
// ----------------------------------------------------------------------------
// Output: the first word of a text byte is valid in the cycle after it is taken.
// Throughput: one text byte per cycle while each gives one word and no stall;
//   a byte that gives several words holds the result register until its last
//   word is taken at the single output port. A held colon gives no word.
// Reset: rst clears the scan state to base text and empties the result
//   register; the block is ready for text as soon as reset is released.
// ----------------------------------------------------------------------------
module sql_bind_variable_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       is_final,
  output logic       token_valid,
  input  logic       token_stall,
  output logic [2:0] token_kind,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import sbvt_pkg::*;

  token_list_t list;
  token_t      token;
  logic        ready;
  logic        accept;

  assign text_stall = !ready;
  assign accept     = text_valid && ready;

  // Per-byte decision and scan state
  sbvt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .is_final  (is_final),
    .list      (list)
  );

  // Result register and word sequencing
  sbvt_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .list        (list),
    .ready       (ready),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  assign token_kind = token.kind;
  assign out_byte   = token.data;
  assign run_last   = token.last;

endmodule
